// ===== hw/rtl/tcl_pkg.sv =====
package tcl_pkg;

   localparam int ADDR_BITS      = 32;
   localparam int LINE_BITS      = 32;
   localparam int BYTE_BITS      = 2;
   localparam int SET_BITS       = 14;
   localparam int TAG_BITS       = ADDR_BITS - BYTE_BITS - SET_BITS;
   localparam int NUM_SETS       = 1 << SET_BITS;
   localparam int DATA_BITS      = 8;
   localparam int COUNT_BITS     = 32;
   localparam int NUM_WAYS       = 2;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef logic [SET_BITS-1:0]  set_type;
   typedef logic [TAG_BITS-1:0]  tag_type;
   typedef logic [BYTE_BITS-1:0] byte_sel_type;
   typedef logic [LINE_BITS-1:0] line_type;

   typedef struct packed {
      tag_type      tag;
      set_type      set;
      byte_sel_type byte_sel;
      line_type     fill_line;
   } tcl_item_type;

   typedef struct packed {
      logic         valid;
      tcl_item_type item;
   } tcl_head_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } tcl_back_stat_type;

   typedef struct packed {
      tag_type  tag;
      line_type line;
   } tcl_way_word_type;

   typedef struct packed {
      logic [NUM_WAYS-1:0] valid;
      logic                victim;
   } tcl_meta_type;

   localparam int WAY_WORD_BITS = $bits(tcl_way_word_type);
   localparam int META_BITS     = $bits(tcl_meta_type);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_ISSUE,
      ST_LOOKUP
   } tcl_state_type;

endpackage

// ===== hw/rtl/tcl_req_if.sv =====
interface tcl_req_if;
   logic                           valid;
   logic                           ready;
   logic [tcl_pkg::ADDR_BITS-1:0]  address;
   logic [tcl_pkg::LINE_BITS-1:0]  fill_line;

   modport source (output valid, output address, output fill_line, input ready);
   modport sink   (input valid, input address, input fill_line, output ready);
endinterface

// ===== hw/rtl/tcl_rsp_if.sv =====
interface tcl_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [tcl_pkg::DATA_BITS-1:0]   read_byte;
   logic                            was_hit;
   logic                            way_used;
   logic [tcl_pkg::COUNT_BITS-1:0]  hits_so_far;
   logic [tcl_pkg::COUNT_BITS-1:0]  misses_so_far;

   modport source (output valid, output read_byte, output was_hit, output way_used,
                   output hits_so_far, output misses_so_far, input ready);
   modport sink   (input valid, input read_byte, input was_hit, input way_used,
                   input hits_so_far, input misses_so_far, output ready);
endinterface

// ===== hw/rtl/tcl_ram.sv =====
module tcl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/tcl_front.sv =====
module tcl_front (
   input  logic                       clock,
   input  logic                       reset,
   tcl_req_if.sink                    req_bus,
   input  tcl_pkg::tcl_back_stat_type stat,
   output tcl_pkg::tcl_head_type      head
);

   tcl_pkg::tcl_item_type                 entry_ff [tcl_pkg::QUEUE_DEPTH];
   logic [tcl_pkg::QUEUE_PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [tcl_pkg::QUEUE_PTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [tcl_pkg::QUEUE_CNT_BITS-1:0]    count_ff, count_in;
   tcl_pkg::tcl_item_type                 word;
   logic                                  push;
   logic                                  pop;

   assign req_bus.ready = (count_ff != tcl_pkg::QUEUE_CNT_BITS'(tcl_pkg::QUEUE_DEPTH))
                          && !stat.clearing;
   assign push = req_bus.valid && req_bus.ready;
   assign pop  = stat.pop && (count_ff != '0);

   // classify: split the address into tag, set and byte
   always_comb begin
      word.byte_sel  = req_bus.address[tcl_pkg::BYTE_BITS-1:0];
      word.set       = req_bus.address[tcl_pkg::BYTE_BITS +: tcl_pkg::SET_BITS];
      word.tag       = req_bus.address[tcl_pkg::ADDR_BITS-1 -: tcl_pkg::TAG_BITS];
      word.fill_line = req_bus.fill_line;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == tcl_pkg::QUEUE_PTR_BITS'(tcl_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == tcl_pkg::QUEUE_PTR_BITS'(tcl_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= word;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.item  = entry_ff[rd_ptr_ff];

endmodule

// ===== hw/rtl/tcl_back.sv =====
module tcl_back (
   input  logic                       clock,
   input  logic                       reset,
   input  tcl_pkg::tcl_head_type      head,
   output tcl_pkg::tcl_back_stat_type stat,
   tcl_rsp_if.source                  rsp_bus
);

   tcl_pkg::tcl_state_type                 state_ff, state_in;
   tcl_pkg::set_type                       clr_ff, clr_in;
   tcl_pkg::tcl_item_type                  cur_ff, cur_in;
   logic                                   out_valid_ff, out_valid_in;
   logic [tcl_pkg::DATA_BITS-1:0]          out_byte_ff, out_byte_in;
   logic                                   out_hit_ff, out_hit_in;
   logic                                   out_way_ff, out_way_in;
   logic [tcl_pkg::COUNT_BITS-1:0]         hits_ff, hits_in;
   logic [tcl_pkg::COUNT_BITS-1:0]         misses_ff, misses_in;

   logic                                   issue_go;
   logic                                   rsp_fire;
   tcl_pkg::set_type                       rd_set;
   logic [tcl_pkg::NUM_WAYS-1:0]           way_wr_en;
   tcl_pkg::tcl_way_word_type              way_wr_word;
   logic [tcl_pkg::WAY_WORD_BITS-1:0]      way_rd_bits [tcl_pkg::NUM_WAYS];
   tcl_pkg::tcl_way_word_type              way_rd_word [tcl_pkg::NUM_WAYS];
   logic                                   meta_wr_en;
   tcl_pkg::set_type                       meta_wr_addr;
   tcl_pkg::tcl_meta_type                  meta_wr_word;
   logic [tcl_pkg::META_BITS-1:0]          meta_rd_bits;
   tcl_pkg::tcl_meta_type                  meta_rd_word;
   logic                                   hit0;
   logic                                   hit1;
   logic                                   hit;
   logic                                   way;
   tcl_pkg::line_type                      line;

   assign rsp_fire = rsp_bus.valid && rsp_bus.ready;
   assign issue_go = (state_ff == tcl_pkg::ST_ISSUE) && head.valid
                     && (!out_valid_ff || rsp_bus.ready);
   assign rd_set   = head.item.set;

   for (genvar w = 0; w < tcl_pkg::NUM_WAYS; w++) begin : g_way
      tcl_ram #(
         .WIDTH (tcl_pkg::WAY_WORD_BITS),
         .DEPTH (tcl_pkg::NUM_SETS)
      ) u_way_ram (
         .clock   (clock),
         .wr_en   (way_wr_en[w]),
         .wr_addr (cur_ff.set),
         .wr_data (way_wr_word),
         .rd_addr (rd_set),
         .rd_data (way_rd_bits[w])
      );
      assign way_rd_word[w] = tcl_pkg::tcl_way_word_type'(way_rd_bits[w]);
   end

   tcl_ram #(
      .WIDTH (tcl_pkg::META_BITS),
      .DEPTH (tcl_pkg::NUM_SETS)
   ) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_wr_en),
      .wr_addr (meta_wr_addr),
      .wr_data (meta_wr_word),
      .rd_addr (rd_set),
      .rd_data (meta_rd_bits)
   );
   assign meta_rd_word = tcl_pkg::tcl_meta_type'(meta_rd_bits);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tcl_pkg::ST_CLEAR: begin
            if (clr_ff == '1) begin
               state_in = tcl_pkg::ST_ISSUE;
            end
         end
         tcl_pkg::ST_ISSUE: begin
            if (issue_go) begin
               state_in = tcl_pkg::ST_LOOKUP;
            end
         end
         tcl_pkg::ST_LOOKUP: begin
            state_in = tcl_pkg::ST_ISSUE;
         end
         default: begin
            state_in = tcl_pkg::ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      hit0 = meta_rd_word.valid[0] && (way_rd_word[0].tag == cur_ff.tag);
      hit1 = meta_rd_word.valid[1] && (way_rd_word[1].tag == cur_ff.tag) && !hit0;
      hit  = hit0 || hit1;
      way  = hit0 ? 1'b0 : (hit1 ? 1'b1 : meta_rd_word.victim);
      line = hit ? way_rd_word[way].line : cur_ff.fill_line;
   end

   always_comb begin
      clr_in       = clr_ff;
      cur_in       = cur_ff;
      out_valid_in = out_valid_ff && !rsp_fire;
      out_byte_in  = out_byte_ff;
      out_hit_in   = out_hit_ff;
      out_way_in   = out_way_ff;
      hits_in      = hits_ff;
      misses_in    = misses_ff;
      way_wr_en    = '0;
      way_wr_word  = '{tag: cur_ff.tag, line: cur_ff.fill_line};
      meta_wr_en   = 1'b0;
      meta_wr_addr = cur_ff.set;
      meta_wr_word = '0;
      stat.pop      = issue_go;
      stat.clearing = (state_ff == tcl_pkg::ST_CLEAR);
      unique case (state_ff)
         tcl_pkg::ST_CLEAR: begin
            meta_wr_en   = 1'b1;
            meta_wr_addr = clr_ff;
            clr_in       = clr_ff + 1'b1;
         end
         tcl_pkg::ST_ISSUE: begin
            if (issue_go) begin
               cur_in = head.item;
            end
         end
         tcl_pkg::ST_LOOKUP: begin
            way_wr_en[way]         = !hit;
            meta_wr_en             = 1'b1;
            meta_wr_word.valid     = meta_rd_word.valid;
            meta_wr_word.valid[way] = 1'b1;
            meta_wr_word.victim    = ~way;
            out_valid_in           = 1'b1;
            out_byte_in            = line[tcl_pkg::DATA_BITS * cur_ff.byte_sel +:
                                          tcl_pkg::DATA_BITS];
            out_hit_in             = hit;
            out_way_in             = way;
            if (hit) begin
               if (hits_ff != '1) begin
                  hits_in = hits_ff + 1'b1;
               end
            end else begin
               if (misses_ff != '1) begin
                  misses_in = misses_ff + 1'b1;
               end
            end
         end
         default: begin
            meta_wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcl_pkg::ST_CLEAR;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
         hits_ff      <= '0;
         misses_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         out_valid_ff <= out_valid_in;
         hits_ff      <= hits_in;
         misses_ff    <= misses_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      out_byte_ff <= out_byte_in;
      out_hit_ff  <= out_hit_in;
      out_way_ff  <= out_way_in;
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.read_byte     = out_byte_ff;
   assign rsp_bus.was_hit       = out_hit_ff;
   assign rsp_bus.way_used      = out_way_ff;
   assign rsp_bus.hits_so_far   = hits_ff;
   assign rsp_bus.misses_so_far = misses_ff;

endmodule

// ===== hw/rtl/two_way_cache_lookup_fill_top.sv =====
// Read-only two-way set-associative cache with 4-byte lines and one LRU bit per
// set. Each request word carries a byte address and the line to install on a
// miss; each response word returns the addressed byte, hit flag, way used and
// saturating hit and miss totals. Requests queue in a two-entry buffer; the
// lookup engine then handles each word in ISSUE, which starts the registered
// read of the set's tag/data and state RAMs, then in LOOKUP, which compares,
// fills and updates LRU. After reset the engine sweeps all 16384 sets of the
// state RAM, one set per cycle, before the first request is accepted.
module two_way_cache_lookup_fill_top (
   input  logic       clock,
   input  logic       reset,
   tcl_req_if.sink    req_bus,
   tcl_rsp_if.source  rsp_bus
);

   tcl_pkg::tcl_head_type      head;
   tcl_pkg::tcl_back_stat_type stat;

   tcl_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .stat    (stat),
      .head    (head)
   );

   tcl_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (head),
      .stat    (stat),
      .rsp_bus (rsp_bus)
   );

endmodule

// ===== tb/sv/two_way_cache_lookup_fill_top_tb.sv =====
`timescale 1ns / 1ps

module two_way_cache_lookup_fill_top_tb;

   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned DRAIN_CYCLES = 24;
   localparam int unsigned PHASE_WORDS  = 600;
   localparam int unsigned HOLD_AFTER   = 150;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned SET_POOL     = 8;
   localparam int unsigned TAG_POOL     = 6;

   typedef struct packed {
      logic [tcl_pkg::DATA_BITS-1:0]  read_byte;
      logic                           was_hit;
      logic                           way_used;
      logic [tcl_pkg::COUNT_BITS-1:0] hits_so_far;
      logic [tcl_pkg::COUNT_BITS-1:0] misses_so_far;
   } cache_reply_type;

   class cache_scoreboard;
      bit                             way_valid [tcl_pkg::NUM_WAYS][tcl_pkg::NUM_SETS];
      tcl_pkg::tag_type               way_tag   [tcl_pkg::NUM_WAYS][tcl_pkg::NUM_SETS];
      tcl_pkg::line_type              way_line  [tcl_pkg::NUM_WAYS][tcl_pkg::NUM_SETS];
      bit                             lru_victim[tcl_pkg::NUM_SETS];
      logic [tcl_pkg::COUNT_BITS-1:0] hit_count;
      logic [tcl_pkg::COUNT_BITS-1:0] miss_count;
      cache_reply_type                pending_replies[$];
      int unsigned                    errors;
      int unsigned                    replies_checked;

      function new();
         for (int s = 0; s < tcl_pkg::NUM_SETS; s++) begin
            lru_victim[s] = 1'b0;
            for (int w = 0; w < tcl_pkg::NUM_WAYS; w++) begin
               way_valid[w][s] = 1'b0;
               way_tag[w][s]   = '0;
               way_line[w][s]  = '0;
            end
         end
         hit_count       = '0;
         miss_count      = '0;
         errors          = 0;
         replies_checked = 0;
      endfunction

      function void note_request(logic [tcl_pkg::ADDR_BITS-1:0] address,
                                 tcl_pkg::line_type fill_line);
         tcl_pkg::byte_sel_type sel;
         tcl_pkg::set_type      set;
         tcl_pkg::tag_type      tag;
         bit                    way;
         bit                    hit;
         tcl_pkg::line_type     line;
         cache_reply_type       reply;
         sel = address[tcl_pkg::BYTE_BITS-1:0];
         set = address[tcl_pkg::BYTE_BITS +: tcl_pkg::SET_BITS];
         tag = address[tcl_pkg::ADDR_BITS-1 -: tcl_pkg::TAG_BITS];
         if (way_valid[0][set] && way_tag[0][set] == tag) begin
            way = 1'b0;
            hit = 1'b1;
         end else if (way_valid[1][set] && way_tag[1][set] == tag) begin
            way = 1'b1;
            hit = 1'b1;
         end else begin
            way = lru_victim[set];
            hit = 1'b0;
            way_tag[way][set]   = tag;
            way_line[way][set]  = fill_line;
            way_valid[way][set] = 1'b1;
         end
         lru_victim[set] = ~way;
         if (hit) begin
            if (hit_count != '1) hit_count = hit_count + 1'b1;
         end else begin
            if (miss_count != '1) miss_count = miss_count + 1'b1;
         end
         line                = way_line[way][set];
         reply.read_byte     = line[8*sel +: tcl_pkg::DATA_BITS];
         reply.was_hit       = hit;
         reply.way_used      = way;
         reply.hits_so_far   = hit_count;
         reply.misses_so_far = miss_count;
         pending_replies.push_back(reply);
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         $display("mismatch on %s at reply %0d: got %h, expected %h",
                  what, replies_checked, got, want);
         errors++;
      endtask

      task check_reply(cache_reply_type got);
         cache_reply_type want;
         if (pending_replies.size() == 0) begin
            report_mismatch("unexpected reply", 32'(got.read_byte), '0);
         end else begin
            want = pending_replies.pop_front();
            if (got.read_byte !== want.read_byte)
               report_mismatch("read_byte", 32'(got.read_byte), 32'(want.read_byte));
            if (got.was_hit !== want.was_hit)
               report_mismatch("was_hit", 32'(got.was_hit), 32'(want.was_hit));
            if (got.way_used !== want.way_used)
               report_mismatch("way_used", 32'(got.way_used), 32'(want.way_used));
            if (got.hits_so_far !== want.hits_so_far)
               report_mismatch("hits_so_far", got.hits_so_far, want.hits_so_far);
            if (got.misses_so_far !== want.misses_so_far)
               report_mismatch("misses_so_far", got.misses_so_far, want.misses_so_far);
         end
         replies_checked++;
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;

   tcl_req_if req_bus ();
   tcl_rsp_if rsp_bus ();

   two_way_cache_lookup_fill_top uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   cache_scoreboard sb = new();

   int unsigned      send_idle_pct = 34;
   int unsigned      recv_idle_pct = 47;
   int unsigned      cycle_count   = 0;
   tcl_pkg::set_type set_choices[SET_POOL];
   tcl_pkg::tag_type tag_choices[TAG_POOL];

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic send_request(logic [tcl_pkg::ADDR_BITS-1:0] address,
                               tcl_pkg::line_type fill_line);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.address   <= address;
      req_bus.fill_line <= fill_line;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sb.note_request(address, fill_line);
   endtask

   task automatic refresh_pools();
      for (int i = 0; i < SET_POOL; i++) set_choices[i] = tcl_pkg::set_type'($urandom());
      for (int i = 0; i < TAG_POOL; i++) tag_choices[i] = tcl_pkg::tag_type'($urandom());
      set_choices[0] = '0;
      set_choices[1] = '1;
      tag_choices[0] = '0;
      tag_choices[1] = '1;
   endtask

   function automatic logic [tcl_pkg::ADDR_BITS-1:0] pick_address();
      logic [tcl_pkg::ADDR_BITS-1:0] address;
      int unsigned                   tag_index;
      address = $urandom();
      if ($urandom_range(99) >= 10) begin
         tag_index = ($urandom_range(3) == 0) ? $urandom_range(TAG_POOL-1) : $urandom_range(2);
         address[tcl_pkg::BYTE_BITS +: tcl_pkg::SET_BITS] =
            set_choices[$urandom_range(SET_POOL-1)];
         address[tcl_pkg::ADDR_BITS-1 -: tcl_pkg::TAG_BITS] = tag_choices[tag_index];
      end
      return address;
   endfunction

   task automatic run_random(int unsigned count);
      refresh_pools();
      repeat (count) send_request(pick_address(), $urandom());
   endtask

   initial begin : reply_sink
      int unsigned     hold_left;
      bit              hold_done;
      cache_reply_type got;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got.read_byte     = rsp_bus.read_byte;
            got.was_hit       = rsp_bus.was_hit;
            got.way_used      = rsp_bus.way_used;
            got.hits_so_far   = rsp_bus.hits_so_far;
            got.misses_so_far = rsp_bus.misses_so_far;
            sb.check_reply(got);
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!hold_done && sb.replies_checked == HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin : request_source
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.address   <= '0;
      req_bus.fill_line <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_request(32'h0000_0000, 32'h4433_2211);
      send_request(32'h0000_0001, $urandom());
      send_request(32'h0000_0002, $urandom());
      send_request(32'h0000_0003, $urandom());
      send_request(32'h0001_0000, 32'hDDCC_BBAA);
      send_request(32'h0000_0002, $urandom());
      send_request(32'h0002_0003, 32'h1234_5678);
      send_request(32'h0001_0001, 32'h0F0F_F0F0);
      send_request(32'h0002_0000, $urandom());
      send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(32'hFFFF_FFFC, 32'h0000_0000);
      send_request(32'hFFFE_FFFF, 32'h0000_0000);
      send_request(32'hFFFF_FFFE, $urandom());
      send_request(32'hFFFE_FFFD, $urandom());
      send_request(32'h0000_FFFC, 32'h8000_0001);
      send_request(32'h0000_FFFF, $urandom());
      send_request(32'hFFFF_0000, 32'h5A5A_A5A5);
      send_request(32'hFFFF_0003, $urandom());
      send_request(32'h5555_AAAA, 32'hAAAA_5555);
      send_request(32'hAAAA_5555, 32'h5555_AAAA);

      run_random(PHASE_WORDS);
      send_idle_pct = 47;
      recv_idle_pct = 34;
      run_random(PHASE_WORDS);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(PHASE_WORDS);
      req_bus.valid <= 1'b0;

      while (sb.pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/tcl_pkg.sv
hw/rtl/tcl_req_if.sv
hw/rtl/tcl_rsp_if.sv
hw/rtl/tcl_ram.sv
hw/rtl/tcl_front.sv
hw/rtl/tcl_back.sv
hw/rtl/two_way_cache_lookup_fill_top.sv
tb/sv/two_way_cache_lookup_fill_top_tb.sv
